// ----- design/bezier_curve_evaluator_defines.svh -----
// Assertion helpers for the curve evaluator.
`ifndef BEZIER_CURVE_EVALUATOR_DEFINES_SVH
`define BEZIER_CURVE_EVALUATOR_DEFINES_SVH

// same-cycle implication
`define BCE_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BCE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/bce_pkg.sv -----
package bce_pkg;

	localparam int MAX_POINTS = 8;
	localparam int COORD_W    = 24;
	localparam int Q_W        = 17;
	localparam int FRAC_W     = 16;
	localparam int SEG_W      = 6;
	localparam int NUM_W      = SEG_W + FRAC_W;
	localparam int DIV_CNT_W  = $clog2(NUM_W);
	localparam int PIDX_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = 4;
	localparam int BINOM_W    = MAX_POINTS - 1;
	localparam int W_W        = Q_W + BINOM_W;
	localparam int TERM_W     = COORD_W + W_W + 1 - FRAC_W;
	localparam int ACC_W      = COORD_W + MAX_POINTS + 2;

	localparam logic [Q_W-1:0] ONE_Q16 = Q_W'(1 << FRAC_W);
	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_EVAL = 2'd1,
		OP_TESS = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		REG_POINT_COUNT = 2'd0,
		REG_SEGMENTS    = 2'd1,
		REG_CLOSED      = 2'd2
	} reg_idx_t;

	typedef logic [MAX_POINTS-1:0][MAX_POINTS-1:0][BINOM_W-1:0] binom_tab_t;

	// Pascal's triangle, row n holds binomial(n, k)
	function automatic binom_tab_t make_binom();
		binom_tab_t tab;
		int row [MAX_POINTS];
		tab = '0;
		for (int k = 0; k < MAX_POINTS; k++) row[k] = 0;
		for (int n = 0; n < MAX_POINTS; n++) begin
			row[n] = 1;
			for (int k = n - 1; k >= 1; k--) row[k] = row[k] + row[k-1];
			row[0] = 1;
			for (int k = 0; k <= n; k++) tab[n][k] = BINOM_W'(row[k]);
		end
		return tab;
	endfunction

	localparam binom_tab_t BINOM_TAB = make_binom();

	// reset contents of the control point store, {x, y, z}
	function automatic logic [3*COORD_W-1:0] default_point(logic [PIDX_W-1:0] idx);
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		x = '0;
		y = '0;
		case (int'(idx))
			0: begin x = -24'sd65536; y = 24'sd0;     end
			1: begin x = -24'sd32768; y = 24'sd65536; end
			2: begin x = 24'sd32768;  y = 24'sd65536; end
			3: begin x = 24'sd65536;  y = 24'sd0;     end
			default: begin x = '0; y = '0; end
		endcase
		return {x, y, {COORD_W{1'b0}}};
	endfunction

endpackage

// ----- design/bezier_curve_evaluator.sv -----
// Bezier curve evaluator, up to MAX_POINTS control points in Q7.16, Bernstein form.
// A load writes the point store and leaves the evaluator idle. An evaluate with
// p = point_count points runs p power steps, then p reads through a four-stage
// multiply pipeline over the point and power memories, then posts the result.
// Each tessellated point first runs a bit-serial divider that forms
// t = floor(i*65536/segments). The output has its own register, so new
// requests are taken while a result waits; the next point stalls only in the
// final step if the previous one has not been taken.
`include "bezier_curve_evaluator_defines.svh"

module bezier_curve_evaluator import bce_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                op,
	input  logic [2:0]                point_index,
	input  logic signed [COORD_W-1:0] x_in,
	input  logic signed [COORD_W-1:0] y_in,
	input  logic signed [COORD_W-1:0] z_in,
	input  logic [Q_W-1:0]            t_in,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [COORD_W-1:0] x_out,
	output logic signed [COORD_W-1:0] y_out,
	output logic signed [COORD_W-1:0] z_out,
	output logic                      last,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [SEG_W-1:0]          cfg_data
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DIV  = 6'b000010,
		ST_POW  = 6'b000100,
		ST_ACC  = 6'b001000,
		ST_FIN  = 6'b010000,
		ST_REP  = 6'b100000
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0] point_count_q;
	logic [SEG_W-1:0] segments_q;
	logic             closed_q;

	logic             accept_in;
	logic             slot_free;
	logic             push;
	logic [CNT_W-1:0] cnt_now;
	logic             zero_now;

	logic              op_tess_q;
	logic              closed_run_q;
	logic              cnt_zero_q;
	logic [PIDX_W-1:0] n_q;
	logic [PIDX_W-1:0] k_q;
	logic              issue_done_q;
	logic [Q_W-1:0]    t_q;
	logic [Q_W-1:0]    u;
	logic [Q_W-1:0]    pt_q;
	logic [Q_W-1:0]    pu_q;
	logic [SEG_W-1:0]  seg_eff_q;
	logic [SEG_W-1:0]  pt_idx_q;

	logic [SEG_W-1:0]     rem_q;
	logic [NUM_W-1:0]     num_q;
	logic [NUM_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [SEG_W:0]       rem_sh;
	logic                 div_ge;
	logic [NUM_W-1:0]     quo_next;

	logic [3*COORD_W-1:0] pnt_mem [MAX_POINTS];
	logic [Q_W-1:0]       pt_mem  [MAX_POINTS];
	logic [Q_W-1:0]       pu_mem  [MAX_POINTS];
	logic [MAX_POINTS-1:0] pnt_vld_q;
	logic                  pnt_we;
	logic [PIDX_W-1:0]     pnt_waddr;

	logic                 v_s1, v_s2, v_s3, v_s4;
	logic [3*COORD_W-1:0] pnt_rd_s1;
	logic                 pvld_s1;
	logic [Q_W-1:0]       pt_rd_s1, pu_rd_s1;
	logic [PIDX_W-1:0]    i_s1;
	logic [Q_W-1:0]       q_s2;
	logic [BINOM_W-1:0]   binom_s2;
	logic [3*COORD_W-1:0] c_s2, c_s3;
	logic [W_W-1:0]       w_s3;
	logic signed [TERM_W-1:0] tx_s4, ty_s4, tz_s4;
	logic signed [COORD_W+W_W:0] px, py, pz;

	logic signed [ACC_W-1:0]   acc_x_q, acc_y_q, acc_z_q;
	logic signed [COORD_W-1:0] res_x, res_y, res_z;
	logic signed [COORD_W-1:0] first_x_q, first_y_q, first_z_q;
	logic signed [COORD_W-1:0] x_q, y_q, z_q;
	logic                      out_valid_q, last_q;
	logic                      fin_last;

	function automatic logic signed [COORD_W-1:0] sat(logic signed [ACC_W-1:0] v);
		if (v > ACC_W'(COORD_MAX)) return COORD_MAX;
		if (v < ACC_W'(COORD_MIN)) return COORD_MIN;
		return v[COORD_W-1:0];
	endfunction

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= CNT_W'(4);
			segments_q    <= SEG_W'(32);
			closed_q      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POINT_COUNT: point_count_q <= cfg_data[CNT_W-1:0];
				REG_SEGMENTS:    segments_q    <= cfg_data;
				REG_CLOSED:      closed_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign accept_in = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign push      = slot_free && (state_q == ST_FIN || state_q == ST_REP);

	assign cnt_now  = (int'(point_count_q) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : point_count_q;
	assign zero_now = (cnt_now == '0);
	assign u        = ONE_Q16 - t_q;

	assign res_x = sat(acc_x_q);
	assign res_y = sat(acc_y_q);
	assign res_z = sat(acc_z_q);
	assign fin_last = !op_tess_q || (pt_idx_q == seg_eff_q && !closed_run_q);

	// divider step: restoring, one quotient bit per cycle
	assign rem_sh   = {rem_q, num_q[NUM_W-1]};
	assign div_ge   = rem_sh >= {1'b0, seg_eff_q};
	assign quo_next = {quo_q[NUM_W-2:0], div_ge};

	// control point store; entries not yet written read as the reset curve
	assign pnt_we    = accept_in && op == OP_LOAD && int'(point_index) < MAX_POINTS;
	assign pnt_waddr = PIDX_W'(point_index);

	always_ff @(posedge clk) begin
		if (pnt_we) pnt_mem[pnt_waddr] <= {x_in, y_in, z_in};
		pnt_rd_s1 <= pnt_mem[k_q];
		pvld_s1   <= pnt_vld_q[k_q];
		if (state_q == ST_POW) begin
			pt_mem[k_q]       <= pt_q;
			pu_mem[n_q - k_q] <= pu_q;
		end
		pt_rd_s1 <= pt_mem[k_q];
		pu_rd_s1 <= pu_mem[k_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pnt_vld_q <= '0;
		else if (pnt_we) pnt_vld_q[pnt_waddr] <= 1'b1;
	end

	// weight and term pipeline
	assign px = $signed(c_s3[3*COORD_W-1:2*COORD_W]) * $signed({1'b0, w_s3});
	assign py = $signed(c_s3[2*COORD_W-1:COORD_W]) * $signed({1'b0, w_s3});
	assign pz = $signed(c_s3[COORD_W-1:0]) * $signed({1'b0, w_s3});

	always_ff @(posedge clk) begin
		i_s1     <= k_q;
		q_s2     <= Q_W'((2*Q_W)'(pt_rd_s1 * pu_rd_s1) >> FRAC_W);
		binom_s2 <= BINOM_TAB[n_q][i_s1];
		c_s2     <= pvld_s1 ? pnt_rd_s1 : default_point(i_s1);
		w_s3     <= W_W'(binom_s2 * q_s2);
		c_s3     <= c_s2;
		tx_s4    <= px[COORD_W+W_W:FRAC_W];
		ty_s4    <= py[COORD_W+W_W:FRAC_W];
		tz_s4    <= pz[COORD_W+W_W:FRAC_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_ACC) && !issue_done_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_tess_q    <= 1'b0;
			closed_run_q <= 1'b0;
			cnt_zero_q   <= 1'b0;
			n_q          <= '0;
			k_q          <= '0;
			issue_done_q <= 1'b0;
			t_q          <= '0;
			pt_q         <= '0;
			pu_q         <= '0;
			seg_eff_q    <= SEG_W'(1);
			pt_idx_q     <= '0;
			rem_q        <= '0;
			num_q        <= '0;
			quo_q        <= '0;
			div_cnt_q    <= '0;
			acc_x_q      <= '0;
			acc_y_q      <= '0;
			acc_z_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept_in && (op == OP_EVAL || op == OP_TESS)) begin
						cnt_zero_q   <= zero_now;
						n_q          <= PIDX_W'(cnt_now - CNT_W'(1));
						closed_run_q <= closed_q;
						seg_eff_q    <= (segments_q == '0) ? SEG_W'(1) : segments_q;
						pt_idx_q     <= '0;
						acc_x_q      <= '0;
						acc_y_q      <= '0;
						acc_z_q      <= '0;
						pt_q         <= ONE_Q16;
						pu_q         <= ONE_Q16;
						k_q          <= '0;
						if (op == OP_EVAL) begin
							op_tess_q <= 1'b0;
							t_q       <= (t_in > ONE_Q16) ? ONE_Q16 : t_in;
							state_q   <= zero_now ? ST_FIN : ST_POW;
						end else begin
							op_tess_q <= 1'b1;
							num_q     <= '0;
							rem_q     <= '0;
							div_cnt_q <= '0;
							state_q   <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					rem_q     <= div_ge ? SEG_W'(rem_sh - {1'b0, seg_eff_q}) : rem_sh[SEG_W-1:0];
					num_q     <= num_q << 1;
					quo_q     <= quo_next;
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_CNT_W'(NUM_W - 1)) begin
						t_q     <= quo_next[Q_W-1:0];
						pt_q    <= ONE_Q16;
						pu_q    <= ONE_Q16;
						k_q     <= '0;
						state_q <= cnt_zero_q ? ST_FIN : ST_POW;
					end
				end
				ST_POW: begin
					pt_q <= Q_W'((2*Q_W)'(pt_q * t_q) >> FRAC_W);
					pu_q <= Q_W'((2*Q_W)'(pu_q * u) >> FRAC_W);
					if (k_q == n_q) begin
						k_q          <= '0;
						issue_done_q <= 1'b0;
						state_q      <= ST_ACC;
					end else begin
						k_q <= k_q + PIDX_W'(1);
					end
				end
				ST_ACC: begin
					if (!issue_done_q) begin
						if (k_q == n_q) issue_done_q <= 1'b1;
						else k_q <= k_q + PIDX_W'(1);
					end
					if (v_s4) begin
						acc_x_q <= acc_x_q + ACC_W'(tx_s4);
						acc_y_q <= acc_y_q + ACC_W'(ty_s4);
						acc_z_q <= acc_z_q + ACC_W'(tz_s4);
					end
					if (issue_done_q && !v_s1 && !v_s2 && !v_s3 && !v_s4) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (slot_free) begin
						acc_x_q <= '0;
						acc_y_q <= '0;
						acc_z_q <= '0;
						if (op_tess_q && pt_idx_q != seg_eff_q) begin
							pt_idx_q  <= pt_idx_q + SEG_W'(1);
							num_q     <= {pt_idx_q + SEG_W'(1), {FRAC_W{1'b0}}};
							rem_q     <= '0;
							div_cnt_q <= '0;
							state_q   <= ST_DIV;
						end else if (op_tess_q && closed_run_q) begin
							state_q <= ST_REP;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_REP: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (state_q == ST_REP) begin
				x_q    <= first_x_q;
				y_q    <= first_y_q;
				z_q    <= first_z_q;
				last_q <= 1'b1;
			end else begin
				x_q    <= res_x;
				y_q    <= res_y;
				z_q    <= res_z;
				last_q <= fin_last;
			end
		end
		if (push && state_q == ST_FIN && pt_idx_q == '0) begin
			first_x_q <= res_x;
			first_y_q <= res_y;
			first_z_q <= res_z;
		end
	end

	assign out_valid = out_valid_q;
	assign x_out     = x_q;
	assign y_out     = y_q;
	assign z_out     = z_q;
	assign last      = last_q;

	`BCE_ASSERT(a_stall_busy, !in_stall, state_q == ST_IDLE, "input taken while busy")
	`BCE_ASSERT(a_pipe_idle, state_q == ST_IDLE, !(v_s1 || v_s2 || v_s3 || v_s4), "pipeline active in idle")
	`BCE_ASSERT(a_div_bound, state_q == ST_DIV, int'(div_cnt_q) < NUM_W, "divider overran")
	`BCE_ASSERT_NEXT(a_push_valid, push, out_valid_q, "result not posted")

endmodule
